// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`endif

// ===== rtl/lefg_pkg.sv =====
// Types, constants and helper functions of the LED effect frame generator.
package lefg_pkg;

  localparam int MATRIX_WIDTH  = 8;
  localparam int MATRIX_HEIGHT = 8;
  localparam int KEY_COUNT     = 6;
  localparam int KEY_W         = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int PIX_W         = 6;
  localparam logic [31:0] FRAME_MS_NUM = 32'd1000;

  typedef enum logic [2:0] {
    CFG_MODE, CFG_RED, CFG_GREEN, CFG_BLUE, CFG_SPEED, CFG_FPS, CFG_LEVEL, CFG_SHOW
  } cfg_idx_t;

  typedef enum logic [3:0] {
    MODE_NONE, MODE_STATIC, MODE_LIVE, MODE_RAINBOW, MODE_BREATHE, MODE_STATIC_RAINBOW,
    MODE_SOLID, MODE_PLASMA, MODE_FIRE, MODE_OCEAN, MODE_RAIN, MODE_SPARKLE,
    MODE_BREATHE_RAINBOW, MODE_SPIRAL, MODE_CYCLE, MODE_REACTIVE
  } mode_t;

  typedef enum logic {CMD_TICK, CMD_KEY} cmd_op_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV_STEP, ST_DIV_CAP, ST_FRAME, ST_RENDER
  } ctrl_state_t;

  typedef struct packed {
    cmd_op_t           op;
    logic [31:0]       now_ms;
    logic [KEY_W-1:0]  key;
  } cmd_t;

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  speed;
    logic [7:0]  fps;
    logic [7:0]  level;
    logic        show;
  } cfg_t;

  typedef logic [KEY_COUNT-1:0][7:0] glow_t;

  typedef struct packed {
    logic         start;
    logic [15:0]  offset;
    glow_t        glow;
  } rnd_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rnd_sts_t;

  // x / 255 for x up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
    return s[15:8];
  endfunction

  function automatic logic [7:0] scale8(input logic [7:0] a, input logic [7:0] b);
    logic [15:0] p;
    p = 16'(a) * 16'(b);
    return div255(p);
  endfunction

endpackage

// ===== rtl/led_effect_frame_generator_top.sv =====
// Sequence: a key transaction is absorbed when popped; a time tick runs the step divide, then
// the frame-rate divide if a cap is set, then a launch state (rainbow and later modes render).
// A frame issues 64 pixels, one per cycle unless out_ready stalls, via s1, s2, out registers.
// Throughput is bounded by the serial divider (one quotient bit per cycle) and the pixel pipe.
// Reset (synchronous, rst_n low) sets config registers to defaults and clears offset, times, glow.
`include "assert_macros.svh"
module led_effect_frame_generator_top import lefg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_kind,
  input  logic [31:0]      in_now_ms,
  input  logic [7:0]       in_key_number,
  input  logic             in_key_down,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] out_pixel_index,
  output logic [7:0]       out_red_out,
  output logic [7:0]       out_green_out,
  output logic [7:0]       out_blue_out,
  output logic             out_frame_end,
  input  logic             cfg_wr_en,
  input  logic [2:0]       cfg_index,
  input  logic [7:0]       cfg_wdata
);

  cfg_t        cfg_r;
  logic        mode_wr;
  logic        q_valid, q_pop;
  cmd_t        q_cmd;
  logic        div_start, div_done;
  logic [31:0] div_dividend, div_quo;
  logic [7:0]  div_divisor, div_rem;
  rnd_ctl_t    rnd_ctl;
  rnd_sts_t    rnd_sts;

  assign mode_wr = cfg_wr_en && (cfg_idx_t'(cfg_index) == CFG_MODE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode  <= MODE_NONE;
      cfg_r.red   <= 8'd255;
      cfg_r.green <= 8'd0;
      cfg_r.blue  <= 8'd0;
      cfg_r.speed <= 8'd50;
      cfg_r.fps   <= 8'd60;
      cfg_r.level <= 8'd255;
      cfg_r.show  <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MODE:  cfg_r.mode  <= mode_t'(cfg_wdata[3:0]);
        CFG_RED:   cfg_r.red   <= cfg_wdata;
        CFG_GREEN: cfg_r.green <= cfg_wdata;
        CFG_BLUE:  cfg_r.blue  <= cfg_wdata;
        CFG_SPEED: cfg_r.speed <= cfg_wdata;
        CFG_FPS:   cfg_r.fps   <= cfg_wdata;
        CFG_LEVEL: cfg_r.level <= cfg_wdata;
        CFG_SHOW:  cfg_r.show  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  lefg_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_now_ms     (in_now_ms),
    .in_key_number (in_key_number),
    .in_key_down   (in_key_down),
    .show          (cfg_r.show),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop)
  );

  lefg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  lefg_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .mode_wr      (mode_wr),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_done     (div_done),
    .div_quo      (div_quo),
    .div_rem      (div_rem),
    .rnd_ctl      (rnd_ctl),
    .rnd_sts      (rnd_sts)
  );

  lefg_render u_render (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .rnd_ctl         (rnd_ctl),
    .rnd_sts         (rnd_sts),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_index (out_pixel_index),
    .out_red_out     (out_red_out),
    .out_green_out   (out_green_out),
    .out_blue_out    (out_blue_out),
    .out_frame_end   (out_frame_end)
  );

  `ASSERT_CLK(a_frame_end_last, out_valid && out_frame_end |-> out_pixel_index == 6'd63, "frame_end off last pixel")
  `ASSERT_CLK(a_div_not_in_frame, div_done |-> !rnd_sts.busy, "divider finished during frame")
  `ASSERT_CLK(a_start_idle, rnd_ctl.start |-> !rnd_sts.busy, "frame launched while busy")
  `ASSERT_NEXT(a_start_busy, rnd_ctl.start, rnd_sts.busy, "frame launch did not start issue")

endmodule

// ===== rtl/lefg_front.sv =====
// Input side: classifies transactions and queues the ones that do work.
module lefg_front import lefg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [31:0] in_now_ms,
  input  logic [7:0]  in_key_number,
  input  logic        in_key_down,
  input  logic        show,
  output logic        q_valid,
  output cmd_t        q_cmd,
  input  logic        q_pop
);

  cmd_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       keep, push, pop;
  cmd_t       cmd;

  always_comb begin
    cmd.op     = in_kind ? CMD_KEY : CMD_TICK;
    cmd.now_ms = in_now_ms;
    cmd.key    = in_key_number[KEY_W-1:0];
    keep       = in_kind ? (in_key_down && (in_key_number < 8'(KEY_COUNT))) : show;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready && keep;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/lefg_div.sv =====
// Radix-2 restoring divider, 32-bit dividend by 8-bit divisor, one bit per cycle.
module lefg_div import lefg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [7:0]  divisor,
  output logic        done,
  output logic [31:0] quo,
  output logic [7:0]  rem
);

  logic [31:0] dvd_r, dvd_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [7:0]  dsr_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [8:0]  trial, diff;
  logic        ge;

  always_comb begin
    trial    = {rem_r, dvd_r[31]};
    diff     = trial - {1'b0, dsr_r};
    ge       = (trial >= {1'b0, dsr_r});
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      rem_nxt  = 8'd0;
      cnt_nxt  = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[30:0], ge};
      rem_nxt = ge ? diff[7:0] : trial[7:0];
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (start) begin
      dsr_r <= divisor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quo  = dvd_r;
  assign rem  = rem_r;

endmodule

// ===== rtl/lefg_ctrl.sv =====
// Back-end sequencer: key glow, step timing, frame gating and frame launch.
module lefg_ctrl import lefg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        mode_wr,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  output logic        div_start,
  output logic [31:0] div_dividend,
  output logic [7:0]  div_divisor,
  input  logic        div_done,
  input  logic [31:0] div_quo,
  input  logic [7:0]  div_rem,
  output rnd_ctl_t    rnd_ctl,
  input  rnd_sts_t    rnd_sts
);

  ctrl_state_t state_r, state_nxt;
  logic [15:0] offset_r, offset_nxt;
  logic [31:0] last_step_r, last_step_nxt;
  logic [31:0] last_frame_r, last_frame_nxt;
  logic [31:0] now_r, now_nxt;
  glow_t       glow_r, glow_nxt;
  logic [7:0]  spd, step_ms, interval;
  logic [15:0] spd_x;
  logic        rnd_start;

  always_comb begin
    spd      = (cfg.speed == 8'd0) ? 8'd1 : cfg.speed;
    spd_x    = 16'(spd) * 16'd195;
    step_ms  = 8'd200 - div255(spd_x);
    interval = (step_ms < 8'd5) ? 8'd5 : step_ms;
  end

  always_comb begin
    state_nxt      = state_r;
    offset_nxt     = offset_r;
    last_step_nxt  = last_step_r;
    last_frame_nxt = last_frame_r;
    now_nxt        = now_r;
    glow_nxt       = glow_r;
    q_pop          = 1'b0;
    div_start      = 1'b0;
    div_dividend   = now_r - last_step_r;
    div_divisor    = interval;
    rnd_start      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_cmd.op == CMD_KEY) begin
            glow_nxt[q_cmd.key] = 8'd255;
          end else begin
            now_nxt      = q_cmd.now_ms;
            div_start    = 1'b1;
            div_dividend = q_cmd.now_ms - last_step_r;
            state_nxt    = ST_DIV_STEP;
          end
        end
      end
      ST_DIV_STEP: begin
        if (div_done) begin
          if (div_quo != 32'd0) begin
            offset_nxt    = offset_r + div_quo[15:0];
            last_step_nxt = now_r - {24'd0, div_rem};
          end
          if (cfg.fps != 8'd0) begin
            div_start    = 1'b1;
            div_dividend = FRAME_MS_NUM;
            div_divisor  = cfg.fps;
            state_nxt    = ST_DIV_CAP;
          end else begin
            state_nxt = ST_FRAME;
          end
        end
      end
      ST_DIV_CAP: begin
        if (div_done) begin
          state_nxt = ((now_r - last_frame_r) < div_quo) ? ST_IDLE : ST_FRAME;
        end
      end
      ST_FRAME: begin
        last_frame_nxt = now_r;
        if (cfg.mode >= MODE_RAINBOW) begin
          rnd_start = 1'b1;
          state_nxt = ST_RENDER;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RENDER: begin
        if (rnd_sts.done) begin
          if (cfg.mode == MODE_REACTIVE) begin
            for (int k = 0; k < KEY_COUNT; k++) begin
              glow_nxt[k] = (glow_r[k] > 8'd8) ? glow_r[k] - 8'd8 : 8'd0;
            end
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (mode_wr) begin
      offset_nxt = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    now_r <= now_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      offset_r     <= 16'd0;
      last_step_r  <= 32'd0;
      last_frame_r <= 32'd0;
      glow_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      offset_r     <= offset_nxt;
      last_step_r  <= last_step_nxt;
      last_frame_r <= last_frame_nxt;
      glow_r       <= glow_nxt;
    end
  end

  always_comb begin
    rnd_ctl.start  = rnd_start;
    rnd_ctl.offset = offset_r;
    rnd_ctl.glow   = glow_r;
  end

endmodule

// ===== rtl/lefg_render.sv =====
// Pixel pipeline: effect select, HSV conversion, brightness scale, output register.
module lefg_render import lefg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  rnd_ctl_t         rnd_ctl,
  output rnd_sts_t         rnd_sts,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] out_pixel_index,
  output logic [7:0]       out_red_out,
  output logic [7:0]       out_green_out,
  output logic [7:0]       out_blue_out,
  output logic             out_frame_end
);

  typedef struct packed {
    logic [PIX_W-1:0] idx;
    logic             hsv;
    logic             scl;
    logic [7:0]       h;
    logic [7:0]       v;
    logic [7:0]       r;
    logic [7:0]       g;
    logic [7:0]       b;
  } pix_t;

  localparam logic [7:0] OCEAN_V [8] = '{8'd255, 8'd230, 8'd204, 8'd179,
                                         8'd153, 8'd128, 8'd102, 8'd77};

  logic             act_r, act_nxt;
  logic [PIX_W-1:0] pix_r, pix_nxt;
  logic             adv, issue, last;
  logic             s1_v_r, s2_v_r, out_v_r;
  pix_t             s1_r, s0;
  logic [PIX_W-1:0] s2_idx_r;
  logic [7:0]       s2_r_r, s2_g_r, s2_b_r;
  logic [7:0]       s1_r8, s1_g8, s1_b8;
  logic [PIX_W-1:0] out_idx_r;
  logic [7:0]       out_r_r, out_g_r, out_b_r;

  // stage 0 locals
  logic [2:0]  x, y, dx, dy;
  logic [7:0]  x8, y8, o8, dsq, bm, b8, brl, heat, wave, depth, col, seed;
  logic [15:0] o;
  logic [4:0]  dx2, dy2;
  logic [16:0] nf, nr;
  logic [32:0] fq;
  logic [33:0] rq;
  logic [11:0] fqq;
  logic [16:0] m40;
  logic [2:0]  row, d;
  logic [7:0]  gl [8];

  // stage 1 locals
  logic [2:0]  sec;
  logic [7:0]  base, hb, rem, qf, tf, q, t;
  logic [15:0] prq, prt;

  assign adv   = !out_v_r || out_ready;
  assign issue = act_r && adv;
  assign last  = (pix_r == PIX_W'(MATRIX_WIDTH * MATRIX_HEIGHT - 1));

  always_comb begin
    act_nxt = act_r;
    pix_nxt = pix_r;
    if (rnd_ctl.start) begin
      act_nxt = 1'b1;
      pix_nxt = '0;
    end else if (issue) begin
      pix_nxt = pix_r + PIX_W'(1);
      if (last) begin
        act_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    rnd_sts.busy = act_r;
    rnd_sts.done = issue && last;
  end

  // stage 0: effect
  always_comb begin
    x   = pix_r[2:0];
    y   = pix_r[5:3];
    x8  = {5'd0, x};
    y8  = {5'd0, y};
    o   = rnd_ctl.offset;
    o8  = o[7:0];
    dx  = (x > 3'd4) ? x - 3'd4 : 3'd4 - x;
    dy  = (y > 3'd4) ? y - 3'd4 : 3'd4 - y;
    dx2 = 5'(dx) * 5'(dx);
    dy2 = 5'(dy) * 5'(dy);
    dsq = 8'(dx2) + 8'(dy2);
    bm  = {1'b0, o[6:0]};
    b8  = (bm > 8'd64) ? 8'd128 - bm : bm;
    brl = 8'((16'(b8) * 16'd255) >> 6);
    nf  = {1'b0, o} + 17'(x8 * 8'd7);
    fq  = 33'(nf) * 33'd52429;
    fqq = fq[32:21];
    m40 = nf - 17'(fqq) * 17'd40;
    heat = 8'((8'd7 - y8) * 8'd30) + m40[7:0];
    wave  = x8 * 8'd32 + o8 * 8'd3;
    depth = y8 * 8'd20;
    col = x8 * 8'd37;
    nr  = {1'b0, o} + 17'(col);
    rq  = 34'(nr) * 34'd87382;
    row = rq[20:18];
    d   = (y > row) ? y - row : row - y;
    seed = x8 * 8'd13 + y8 * 8'd7 + o8;
    for (int i = 0; i < 8; i++) begin
      gl[i] = 8'd0;
    end
    for (int i = 0; i < KEY_COUNT; i++) begin
      gl[i] = rnd_ctl.glow[i];
    end

    s0.idx = pix_r;
    s0.hsv = 1'b0;
    s0.scl = 1'b0;
    s0.h   = 8'd0;
    s0.v   = 8'd255;
    s0.r   = 8'd0;
    s0.g   = 8'd0;
    s0.b   = 8'd0;
    unique case (cfg.mode) inside
      MODE_NONE, MODE_STATIC, MODE_LIVE: ;
      MODE_RAINBOW: begin
        s0.hsv = 1'b1;
        s0.h   = x8 * 8'd20 + y8 * 8'd20 + o8 * 8'd2;
      end
      MODE_BREATHE: begin
        s0.scl = 1'b1;
        s0.v   = brl;
      end
      MODE_STATIC_RAINBOW: begin
        s0.hsv = 1'b1;
        s0.h   = (x8 + y8) * 8'd32;
      end
      MODE_SOLID: begin
        s0.r = cfg.red;
        s0.g = cfg.green;
        s0.b = cfg.blue;
      end
      MODE_PLASMA: begin
        s0.hsv = 1'b1;
        s0.h   = x8 * 8'd16 + y8 * 8'd16 + (x8 + y8) * 8'd12 + dsq + o8 * 8'd5;
      end
      MODE_FIRE: begin
        if (heat > 8'd200) begin
          s0.r = 8'd255; s0.g = 8'd255; s0.b = 8'd128;
        end else if (heat > 8'd150) begin
          s0.r = 8'd255; s0.g = 8'd170;
        end else if (heat > 8'd80) begin
          s0.r = 8'd255; s0.g = 8'd64;
        end else if (heat > 8'd40) begin
          s0.r = 8'd128;
        end
      end
      MODE_OCEAN: begin
        s0.hsv = 1'b1;
        s0.h   = 8'd140 + {4'd0, wave[7:4]} + {3'd0, depth[7:3]};
        s0.v   = OCEAN_V[y];
      end
      MODE_RAIN: begin
        if (d == 3'd0) begin
          s0.r = 8'd255; s0.g = 8'd255; s0.b = 8'd255;
        end else if (d == 3'd1) begin
          s0.g = 8'd255;
        end else if (d == 3'd2) begin
          s0.g = 8'd127;
        end else if (d == 3'd3) begin
          s0.g = 8'd85;
        end
      end
      MODE_SPARKLE: begin
        if (seed[4:0] == 5'd0) begin
          s0.r = 8'd255; s0.g = 8'd255; s0.b = 8'd255;
        end else if (seed[4:0] < 5'd3) begin
          s0.hsv = 1'b1;
          s0.h   = o8 + x8 * 8'd32;
          s0.v   = 8'd128;
        end
      end
      MODE_BREATHE_RAINBOW: begin
        s0.hsv = 1'b1;
        s0.h   = o[8:1];
        s0.v   = brl;
      end
      MODE_SPIRAL: begin
        s0.hsv = 1'b1;
        s0.h   = dsq * 8'd8 + (x8 + y8) * 8'd32 + o8 * 8'd3;
      end
      MODE_CYCLE: begin
        s0.hsv = 1'b1;
        s0.h   = o[9:2];
      end
      MODE_REACTIVE: begin
        if (gl[x] != 8'd0) begin
          s0.scl = 1'b1;
          s0.v   = gl[x];
        end else if (x != 3'd0 && gl[x - 3'd1] != 8'd0) begin
          s0.scl = 1'b1;
          s0.v   = gl[x - 3'd1];
        end
      end
      default: ;
    endcase
  end

  // stage 1: HSV with full saturation, or color scale
  always_comb begin
    if (s1_r.h < 8'd43) begin
      sec = 3'd0; base = 8'd0;
    end else if (s1_r.h < 8'd86) begin
      sec = 3'd1; base = 8'd43;
    end else if (s1_r.h < 8'd129) begin
      sec = 3'd2; base = 8'd86;
    end else if (s1_r.h < 8'd172) begin
      sec = 3'd3; base = 8'd129;
    end else if (s1_r.h < 8'd215) begin
      sec = 3'd4; base = 8'd172;
    end else begin
      sec = 3'd5; base = 8'd215;
    end
    hb  = s1_r.h - base;
    rem = hb * 8'd6;
    qf  = 8'd255 - 8'((16'(rem) * 16'd255) >> 8);
    tf  = 8'd255 - 8'((16'(8'd255 - rem) * 16'd255) >> 8);
    prq = 16'(s1_r.v) * 16'(qf);
    prt = 16'(s1_r.v) * 16'(tf);
    q   = prq[15:8];
    t   = prt[15:8];
    s1_r8 = s1_r.r;
    s1_g8 = s1_r.g;
    s1_b8 = s1_r.b;
    if (s1_r.hsv) begin
      case (sec)
        3'd0: begin s1_r8 = s1_r.v; s1_g8 = t;       s1_b8 = 8'd0;   end
        3'd1: begin s1_r8 = q;      s1_g8 = s1_r.v;  s1_b8 = 8'd0;   end
        3'd2: begin s1_r8 = 8'd0;   s1_g8 = s1_r.v;  s1_b8 = t;      end
        3'd3: begin s1_r8 = 8'd0;   s1_g8 = q;       s1_b8 = s1_r.v; end
        3'd4: begin s1_r8 = t;      s1_g8 = 8'd0;    s1_b8 = s1_r.v; end
        default: begin s1_r8 = s1_r.v; s1_g8 = 8'd0; s1_b8 = q;      end
      endcase
    end else if (s1_r.scl) begin
      s1_r8 = scale8(cfg.red, s1_r.v);
      s1_g8 = scale8(cfg.green, s1_r.v);
      s1_b8 = scale8(cfg.blue, s1_r.v);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r     <= s0;
      s2_idx_r <= s1_r.idx;
      s2_r_r   <= s1_r8;
      s2_g_r   <= s1_g8;
      s2_b_r   <= s1_b8;
      out_idx_r <= s2_idx_r;
      out_r_r  <= scale8(s2_r_r, cfg.level);
      out_g_r  <= scale8(s2_g_r, cfg.level);
      out_b_r  <= scale8(s2_b_r, cfg.level);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r   <= 1'b0;
      pix_r   <= '0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      act_r <= act_nxt;
      pix_r <= pix_nxt;
      if (adv) begin
        s1_v_r  <= issue;
        s2_v_r  <= s1_v_r;
        out_v_r <= s2_v_r;
      end
    end
  end

  assign out_valid       = out_v_r;
  assign out_pixel_index = out_idx_r;
  assign out_red_out     = out_r_r;
  assign out_green_out   = out_g_r;
  assign out_blue_out    = out_b_r;
  assign out_frame_end   = (out_idx_r == PIX_W'(MATRIX_WIDTH * MATRIX_HEIGHT - 1));

endmodule
